// ===== design/tfxe_pkg.sv =====
// Package for the frame XOR encoder: slot type, header constants and
// configuration register indexes. No dependencies.
package tfxe_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxBurst = 7;
  localparam int unsigned CountW   = $clog2(MaxBurst + 1);

  localparam logic [ByteW-1:0] FrameSync = 8'hFD;
  localparam logic [ByteW-1:0] FrameZero = 8'h00;
  localparam logic [ByteW-1:0] LenBias   = 8'd3;
  localparam logic [ByteW-1:0] LenMin    = 8'd1;

  // burst sizes
  localparam logic [CountW-1:0] BurstData      = 3'd1;
  localparam logic [CountW-1:0] BurstDataClose = 3'd2;
  localparam logic [CountW-1:0] BurstHdr       = 3'd6;
  localparam logic [CountW-1:0] BurstHdrClose  = 3'd7;

  // configuration register indexes
  localparam logic [ByteW-1:0] CfgCommandWord  = 8'd0;
  localparam logic [ByteW-1:0] CfgTextEncoding = 8'd1;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             frame_end;
  } slot_t;

endpackage

// ===== design/tts_frame_xor_encoder_core.sv =====
// Top level of the frame XOR encoder: header, payload and checksum framing.
// Depends on tfxe_pkg.
//
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       tdata {message_length, data_byte}, tuser first_byte
// m_*       out  m_tvalid / m_tready       tdata out_byte, tlast run_last, tuser frame_end
// cfg_*     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Flow: each input transaction is decoded into a burst of 0 to 7 bytes held in
// a shift line of slots; the burst drains one byte per cycle while m_tready is high.
// A new input transaction is taken while the final byte of the previous burst
// is being taken, so payload bytes run at one per cycle while m_tready is high,
// save where a checksum byte or a frame header is added to the burst.
// Stray payload bytes with no open frame are consumed with no output.
// Reset (rst, synchronous) empties the burst, closes any frame and sets both
// registers to 1. Back-pressure on m_tready simply holds the burst.
module tts_frame_xor_encoder_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] message_length
  input  logic        s_tuser,   // [0] first_byte
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // run_last
  output logic        m_tuser,   // [0] frame_end
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned ByteW    = tfxe_pkg::ByteW;
  localparam int unsigned MaxBurst = tfxe_pkg::MaxBurst;
  localparam int unsigned CountW   = tfxe_pkg::CountW;

  // configuration registers
  logic [ByteW-1:0] command_word;
  logic [ByteW-1:0] text_encoding;

  // framing state
  logic [ByteW-1:0] running_xor;
  logic [ByteW-1:0] bytes_left;

  // burst shift line; slot 0 drives the output
  tfxe_pkg::slot_t  slots [MaxBurst];
  tfxe_pkg::slot_t  slots_next [MaxBurst];
  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;

  logic [ByteW-1:0] data_byte;
  logic [ByteW-1:0] message_length;
  logic             first_byte;

  logic [ByteW-1:0] len_eff;
  logic [ByteW-1:0] len_hdr;
  logic [ByteW-1:0] hdr_xor;
  logic [ByteW-1:0] xor_after;
  logic [ByteW-1:0] left_base;
  logic [ByteW-1:0] left_after;
  logic             emit;
  logic             close;
  logic             take;
  logic             s_accept;
  logic             load;

  assign data_byte      = s_tdata[7:0];
  assign message_length = s_tdata[15:8];
  assign first_byte     = s_tuser;

  // output side
  assign m_tvalid = (count != '0);
  assign m_tdata  = slots[0].data;
  assign m_tuser  = slots[0].frame_end;
  assign m_tlast  = (count == CountW'(1));
  assign take     = m_tvalid && m_tready;

  // take a new transaction once the current burst is gone or finishing
  assign s_tready = (count == '0) || (take && (count == CountW'(1)));
  assign s_accept = s_tvalid && s_tready;

  assign cfg_ready = 1'b1;

  // decode of one input transaction
  assign len_eff    = (message_length == '0) ? tfxe_pkg::LenMin : message_length;
  assign len_hdr    = len_eff + tfxe_pkg::LenBias;
  assign hdr_xor    = tfxe_pkg::FrameSync ^ tfxe_pkg::FrameZero ^ len_hdr
                      ^ command_word ^ text_encoding;
  assign xor_after  = (first_byte ? hdr_xor : running_xor) ^ data_byte;
  assign left_base  = first_byte ? len_eff : bytes_left;
  assign left_after = left_base - ByteW'(1);
  assign emit       = first_byte || (bytes_left != '0);
  assign close      = (left_after == '0);
  assign load       = s_accept && emit;

  always_comb begin
    for (int i = 0; i < MaxBurst; i++) begin
      slots_next[i] = (i + 1 < MaxBurst) ? slots[(i + 1) % MaxBurst] : '0;
    end
    count_next = count;
    if (load) begin
      for (int i = 0; i < MaxBurst; i++) begin
        slots_next[i] = '0;
      end
      if (first_byte) begin
        slots_next[0] = '{data: tfxe_pkg::FrameSync, frame_end: 1'b0};
        slots_next[1] = '{data: tfxe_pkg::FrameZero, frame_end: 1'b0};
        slots_next[2] = '{data: len_hdr,             frame_end: 1'b0};
        slots_next[3] = '{data: command_word,        frame_end: 1'b0};
        slots_next[4] = '{data: text_encoding,       frame_end: 1'b0};
        slots_next[5] = '{data: data_byte,           frame_end: 1'b0};
        slots_next[6] = '{data: xor_after,           frame_end: 1'b1};
        count_next    = close ? tfxe_pkg::BurstHdrClose : tfxe_pkg::BurstHdr;
      end else begin
        slots_next[0] = '{data: data_byte, frame_end: 1'b0};
        slots_next[1] = '{data: xor_after, frame_end: 1'b1};
        count_next    = close ? tfxe_pkg::BurstDataClose : tfxe_pkg::BurstData;
      end
    end else if (take) begin
      count_next = count - CountW'(1);
    end
  end

  // burst storage: payload, no reset needed
  always_ff @(posedge clk) begin
    if (load || take) begin
      for (int i = 0; i < MaxBurst; i++) begin
        slots[i] <= slots_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      running_xor <= '0;
      bytes_left  <= '0;
    end else begin
      count <= count_next;
      if (load) begin
        running_xor <= close ? '0 : xor_after;
        bytes_left  <= left_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_word  <= 8'd1;
      text_encoding <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tfxe_pkg::CfgCommandWord:  command_word  <= cfg_data;
        tfxe_pkg::CfgTextEncoding: text_encoding <= cfg_data;
        default: ;
      endcase
    end
  end

  // checksum byte always closes its burst
  a_chk_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("checksum byte not last of burst");

  // no open frame means a cleared checksum accumulator
  a_xor_clear: assert property (@(posedge clk) disable iff (rst)
    bytes_left == '0 |-> running_xor == '0)
    else $error("running XOR not cleared with frame closed");

  // a loaded burst is presented on the next cycle
  a_load_out: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid)
    else $error("loaded burst not presented");

  // a burst stays presented until its final byte is taken
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    take && !m_tlast |=> m_tvalid)
    else $error("burst broken before final byte");

endmodule
